/* rtl/seven_segment_command_formatter_assert.svh */
// assertion macros for the formatter rtl, used by the sequencer ssc_ctrl
// needs a clk and rst_n in scope where used
`ifndef SEVEN_SEGMENT_COMMAND_FORMATTER_ASSERT_SVH
`define SEVEN_SEGMENT_COMMAND_FORMATTER_ASSERT_SVH

// same-cycle implication, disabled in reset
`define SSC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define SSC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/ssc_pkg.sv */
// shared types, constants and the digit pattern table for the formatter
// no dependencies
package ssc_pkg;

    localparam int OP_W        = 4;
    localparam int POS_W       = 3;
    localparam int VAL_W       = 16;
    localparam int BYTE_W      = 8;
    localparam int BRIGHT_W    = 4;
    localparam int S_TDATA_W   = 24;
    localparam int M_TUSER_W   = 2;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 4;

    // zero bytes sent by a clear
    localparam int CLEAR_COUNT = 6;
    // byte counter of a clear runs up to CLEAR_COUNT + 2
    localparam int CNT_W       = $clog2(CLEAR_COUNT + 3);

    localparam logic [BYTE_W-1:0] DATA_CMD_BYTE   = 8'h40;
    localparam logic [BYTE_W-1:0] ADDR_CMD_BYTE   = 8'hc0;
    localparam logic [BYTE_W-1:0] BRIGHT_CMD_BYTE = 8'h80;
    localparam logic [BYTE_W-1:0] COLON_BIT       = 8'h80;

    // n / 10 == (n * 52429) >> 19 for every 16-bit n
    localparam logic [VAL_W-1:0] DIV10_MUL   = 16'd52429;
    localparam int               DIV10_SHIFT = 19;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR      = 4'd0,
        OP_BITMAP     = 4'd1,
        OP_DIGIT      = 4'd2,
        OP_SEGMENT    = 4'd3,
        OP_DEC4       = 4'd4,
        OP_DEC2       = 4'd5,
        OP_HEX4       = 4'd6,
        OP_HEX2       = 4'd7,
        OP_BRIGHTNESS = 4'd8
    } op_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_CLEAR_BRIGHTNESS = 1'b0,
        REG_COLON_ENABLE     = 1'b1
    } cfg_reg_t;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    // what the datapath puts on the wire for one byte
    typedef enum logic [2:0] {
        KIND_DATA_CMD,
        KIND_CLEAR_ADDR,
        KIND_ADDR,
        KIND_PATTERN,
        KIND_ZERO,
        KIND_BRIGHT_CFG,
        KIND_BRIGHT_VAL
    } kind_t;

    typedef struct packed {
        logic        load;
        logic        emit;
        logic        step;
        kind_t       kind;
        logic        start;
        logic        stop;
        logic        last;
        logic [1:0]  widx;
        op_t         op;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } status_t;

    function automatic logic [BYTE_W-1:0] seg_pattern(input logic [3:0] digit);
        logic [BYTE_W-1:0] pat;
        case (digit)
            4'h0: pat = 8'h3f;
            4'h1: pat = 8'h06;
            4'h2: pat = 8'h5b;
            4'h3: pat = 8'h4f;
            4'h4: pat = 8'h66;
            4'h5: pat = 8'h6d;
            4'h6: pat = 8'h7d;
            4'h7: pat = 8'h07;
            4'h8: pat = 8'h7f;
            4'h9: pat = 8'h6f;
            4'ha: pat = 8'h77;
            4'hb: pat = 8'h7c;
            4'hc: pat = 8'h39;
            4'hd: pat = 8'h5e;
            4'he: pat = 8'h79;
            default: pat = 8'h71;
        endcase
        return pat;
    endfunction

endpackage

/* rtl/ssc_ctrl.sv */
// sequencer for the formatter: walks the bytes of one command
// depends on ssc_pkg and the assertion macro header
`include "seven_segment_command_formatter_assert.svh"

module ssc_ctrl
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [ssc_pkg::OP_W-1:0]  s_op,
    input  ssc_pkg::status_t          status,
    output ssc_pkg::cmd_t             cmd
);
    import ssc_pkg::*;

    state_t           state_reg, state_next;
    op_t              op_reg, op_next;
    logic [1:0]       phase_reg, phase_next;
    logic [1:0]       widx_reg, widx_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [1:0]       widx_final;

    // index of the final pattern write of the command
    always_comb
    begin
        case (op_reg)
            OP_DEC4, OP_HEX4: widx_final = 2'd3;
            OP_DEC2, OP_HEX2: widx_final = 2'd1;
            default:          widx_final = 2'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            op_reg    <= OP_CLEAR;
            phase_reg <= 2'd0;
            widx_reg  <= 2'd0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            phase_reg <= phase_next;
            widx_reg  <= widx_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        phase_next = phase_reg;
        widx_next  = widx_reg;
        cnt_next   = cnt_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        cmd.kind   = KIND_DATA_CMD;
        cmd.op     = op_reg;
        cmd.widx   = widx_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    cmd.op     = op_t'(s_op);
                    op_next    = op_t'(s_op);
                    phase_next = 2'd0;
                    widx_next  = 2'd0;
                    cnt_next   = '0;
                    // unknown operations are dropped here
                    if (s_op <= OP_W'(OP_BRIGHTNESS))
                        state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (op_reg == OP_CLEAR)
                begin
                    if (cnt_reg == CNT_W'(0))
                    begin
                        cmd.kind  = KIND_DATA_CMD;
                        cmd.start = 1'b1;
                        cmd.stop  = 1'b1;
                    end
                    else if (cnt_reg == CNT_W'(1))
                    begin
                        cmd.kind  = KIND_CLEAR_ADDR;
                        cmd.start = 1'b1;
                    end
                    else if (cnt_reg == CNT_W'(CLEAR_COUNT + 2))
                    begin
                        cmd.kind  = KIND_BRIGHT_CFG;
                        cmd.start = 1'b1;
                        cmd.stop  = 1'b1;
                        cmd.last  = 1'b1;
                    end
                    else
                    begin
                        cmd.kind = KIND_ZERO;
                        cmd.stop = (cnt_reg == CNT_W'(CLEAR_COUNT + 1));
                    end
                end
                else if (op_reg == OP_BRIGHTNESS)
                begin
                    cmd.kind  = KIND_BRIGHT_VAL;
                    cmd.start = 1'b1;
                    cmd.stop  = 1'b1;
                    cmd.last  = 1'b1;
                end
                else
                begin
                    case (phase_reg)
                        2'd0:
                        begin
                            cmd.kind  = KIND_DATA_CMD;
                            cmd.start = 1'b1;
                            cmd.stop  = 1'b1;
                        end
                        2'd1:
                        begin
                            cmd.kind  = KIND_ADDR;
                            cmd.start = 1'b1;
                        end
                        default:
                        begin
                            cmd.kind = KIND_PATTERN;
                            cmd.stop = 1'b1;
                            cmd.step = 1'b1;
                            cmd.last = (widx_reg == widx_final);
                        end
                    endcase
                end

                cmd.emit = status.out_free;
                if (cmd.emit)
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                    if (phase_reg == 2'd2)
                    begin
                        phase_next = 2'd0;
                        widx_next  = widx_reg + 2'd1;
                    end
                    else
                    begin
                        phase_next = phase_reg + 2'd1;
                    end
                    if (cmd.last)
                        state_next = ST_IDLE;
                end
            end
        endcase
    end

    `SSC_ASSERT_NOW(a_emit_needs_room, cmd.emit, status.out_free,
        "byte issued while output register is full")
    `SSC_ASSERT_NEXT(a_last_ends_item, cmd.emit && cmd.last, state_reg == ST_IDLE,
        "sequencer kept running after the final byte")
    `SSC_ASSERT_NOW(a_two_digit_bound,
        state_reg == ST_RUN && (op_reg == OP_DEC2 || op_reg == OP_HEX2),
        widx_reg <= 2'd1, "two-digit form ran past its second write")
    `SSC_ASSERT_NOW(a_clear_bound, state_reg == ST_RUN && op_reg == OP_CLEAR,
        cnt_reg <= CNT_W'(CLEAR_COUNT + 2), "clear ran past its final byte")

endmodule

/* rtl/ssc_datapath.sv */
// datapath: config registers, digit extraction, byte assembly, output register
// depends on ssc_pkg
module ssc_datapath
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    input  logic [ssc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ssc_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic [ssc_pkg::POS_W-1:0]       in_position,
    input  logic [ssc_pkg::VAL_W-1:0]       in_value,
    input  ssc_pkg::cmd_t                   cmd,
    output ssc_pkg::status_t                status,
    input  logic                            m_tready,
    output logic                            m_tvalid,
    output logic [ssc_pkg::BYTE_W-1:0]      m_tdata,
    output logic [ssc_pkg::M_TUSER_W-1:0]   m_tuser,
    output logic                            m_tlast
);
    import ssc_pkg::*;

    logic [BRIGHT_W-1:0] clear_brightness_reg;
    logic                colon_enable_reg;
    logic [POS_W-1:0]    pos_reg;
    logic [VAL_W-1:0]    val_reg;
    logic [VAL_W-1:0]    work_reg;
    logic                out_valid_reg;
    logic [BYTE_W-1:0]   out_byte_reg;
    logic                out_start_reg;
    logic                out_stop_reg;
    logic                out_last_reg;

    logic [2*VAL_W-1:0]              prod;
    logic [2*VAL_W-DIV10_SHIFT-1:0]  quot;
    logic [VAL_W-1:0]                quot_x10;
    logic [3:0]                      rem;
    logic                            is_dec;
    logic [1:0]                      base;
    logic [POS_W-1:0]                addr;
    logic [BYTE_W-1:0]               pattern;
    logic [BYTE_W-1:0]               byte_val;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_brightness_reg <= 4'hf;
            colon_enable_reg     <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_CLEAR_BRIGHTNESS: clear_brightness_reg <= cfg_data;
                REG_COLON_ENABLE:     colon_enable_reg     <= cfg_data[0];
            endcase
        end
    end

    // one decimal digit off the working value per pattern write
    assign prod     = work_reg * DIV10_MUL;
    assign quot     = prod[2*VAL_W-1:DIV10_SHIFT];
    assign quot_x10 = VAL_W'({quot, 3'b000}) + VAL_W'({quot, 1'b0});
    assign rem      = 4'(work_reg - quot_x10);
    assign is_dec   = (cmd.op == OP_DEC4) || (cmd.op == OP_DEC2);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            pos_reg  <= in_position;
            val_reg  <= in_value;
            // two-digit decimal only looks at the low byte
            work_reg <= (cmd.op == OP_DEC2) ? {8'h00, in_value[7:0]} : in_value;
        end
        else if (cmd.emit && cmd.step)
        begin
            work_reg <= is_dec ? VAL_W'(quot) : (work_reg >> 4);
        end
    end

    // display address of the current write
    assign base = pos_reg[0] ? 2'd0 : 2'd2;

    always_comb
    begin
        case (cmd.op)
            OP_DEC4, OP_HEX4: addr = {1'b0, ~cmd.widx};
            OP_DEC2:
            begin
                if (pos_reg == 3'd2)
                    addr = (cmd.widx == 2'd0) ? 3'd2 : 3'd1;
                else
                    addr = (cmd.widx == 2'd0) ? {1'b0, base | 2'd1} : {1'b0, base};
            end
            OP_HEX2: addr = (cmd.widx == 2'd0) ? {1'b0, base | 2'd1} : {1'b0, base};
            default: addr = pos_reg;
        endcase
    end

    always_comb
    begin
        case (cmd.op)
            OP_BITMAP:        pattern = val_reg[7:0];
            OP_DIGIT:         pattern = seg_pattern(val_reg[3:0]);
            OP_SEGMENT:       pattern = (val_reg < VAL_W'(8))
                                        ? (8'h01 << val_reg[2:0]) : 8'h00;
            OP_DEC4, OP_DEC2: pattern = seg_pattern(rem);
            OP_HEX4, OP_HEX2: pattern = seg_pattern(work_reg[3:0]);
            default:          pattern = 8'h00;
        endcase
        // colon rides on address 1, never on a single segment
        if (addr == 3'd1 && colon_enable_reg && cmd.op != OP_SEGMENT)
            pattern = pattern | COLON_BIT;
    end

    always_comb
    begin
        unique case (cmd.kind)
            KIND_DATA_CMD:   byte_val = DATA_CMD_BYTE;
            KIND_CLEAR_ADDR: byte_val = ADDR_CMD_BYTE;
            KIND_ADDR:       byte_val = ADDR_CMD_BYTE | BYTE_W'(addr);
            KIND_PATTERN:    byte_val = pattern;
            KIND_ZERO:       byte_val = 8'h00;
            KIND_BRIGHT_CFG: byte_val = BRIGHT_CMD_BYTE | BYTE_W'(clear_brightness_reg);
            KIND_BRIGHT_VAL: byte_val = BRIGHT_CMD_BYTE | BYTE_W'(val_reg[3:0]);
            default:         byte_val = 8'h00;
        endcase
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_byte_reg  <= byte_val;
            out_start_reg <= cmd.start;
            out_stop_reg  <= cmd.stop;
            out_last_reg  <= cmd.last;
        end
    end

    assign status.out_free = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tuser  = {out_stop_reg, out_start_reg};
    assign m_tlast  = out_last_reg;

endmodule

/* rtl/seven_segment_command_formatter.sv */
// the first byte of a command is registered once the sequencer has entered its run state
// and the output register is free; throughput: one byte per cycle while the output is taken;
//   an item holds the sequencer until its final byte is issued: clear 9 bytes, brightness 1,
//   one write 3, two-digit forms 6, four-digit forms 12; unknown operations send no bytes
// the sequencer emits at most one byte per cycle into a single output register
// reset: asynchronous active low; clears brightness to 15 and colon off, idles
module seven_segment_command_formatter
(
    input  logic                            clk,
    input  logic                            rst_n,
    // command items
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [ssc_pkg::S_TDATA_W-1:0]   s_tdata,   // operation[3:0], position[6:4],
                                                       // value[22:7], zero pad[23]
    // frame bytes
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [ssc_pkg::BYTE_W-1:0]      m_tdata,   // frame_byte[7:0]
    output logic [ssc_pkg::M_TUSER_W-1:0]   m_tuser,   // start_before[0], stop_after[1]
    output logic                            m_tlast,   // last byte of the command
    // register writes
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ssc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ssc_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import ssc_pkg::*;

    cmd_t    cmd;
    status_t status;

    // registers are always writable; writes are expected only while idle
    assign cfg_ready = 1'b1;

    // controller: accepts an item, then steps through its bytes
    ssc_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_op     (s_tdata[3:0]),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath: holds the item, extracts digits, builds and registers bytes
    ssc_datapath u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_position (s_tdata[6:4]),
        .in_value    (s_tdata[22:7]),
        .cmd         (cmd),
        .status      (status),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

endmodule

/* sim/tb.sv */
`timescale 1ns / 100ps
// testbench for seven_segment_command_formatter: random and directed display commands
// checked byte by byte against a predictor kept in a scoreboard class
// depends on ssc_pkg and the formatter rtl
module tb;
    import ssc_pkg::*;

    // operation codes the block does not know, they cause no bytes
    localparam logic [OP_W-1:0] OP_UNKNOWN_LO = 4'd9;
    localparam logic [OP_W-1:0] OP_UNKNOWN_HI = 4'd15;

    localparam int CYCLE_LIMIT   = 1000000;
    // a four-digit command holds the sequencer longest, leave margin
    localparam int SETTLE_CYCLES = 20;
    // long receiver hold-off, enough to back up the block and stall its input
    localparam int HOLD_CYCLES   = 300;

    // one frame byte as the display driver should see it
    typedef struct {
        logic [BYTE_W-1:0] frame_byte;
        logic              start_before;
        logic              stop_after;
        logic              last;
    } frame_item_t;

    // predicts the frame bytes of each command and checks what comes out
    class frame_scoreboard;
        frame_item_t        pending_bytes[$];
        logic [BRIGHT_W-1:0] clear_level;
        logic               colon_on;
        int unsigned        mismatches;

        function new();
            clear_level = 4'hf;
            colon_on    = 1'b0;
            mismatches  = 0;
        endfunction

        function int pending();
            return pending_bytes.size();
        endfunction

        function void set_register(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
            if (idx == REG_CLEAR_BRIGHTNESS)
                clear_level = data;
            else
                colon_on = data[0];
        endfunction

        // digit font, 0..f
        function logic [BYTE_W-1:0] glyph(input logic [3:0] digit);
            logic [BYTE_W-1:0] pat;
            case (digit)
                4'h0: pat = 8'h3f;
                4'h1: pat = 8'h06;
                4'h2: pat = 8'h5b;
                4'h3: pat = 8'h4f;
                4'h4: pat = 8'h66;
                4'h5: pat = 8'h6d;
                4'h6: pat = 8'h7d;
                4'h7: pat = 8'h07;
                4'h8: pat = 8'h7f;
                4'h9: pat = 8'h6f;
                4'ha: pat = 8'h77;
                4'hb: pat = 8'h7c;
                4'hc: pat = 8'h39;
                4'hd: pat = 8'h5e;
                4'he: pat = 8'h79;
                default: pat = 8'h71;
            endcase
            return pat;
        endfunction

        function void push_byte(input logic [BYTE_W-1:0] b, input logic st, input logic sp);
            frame_item_t item;
            item.frame_byte   = b;
            item.start_before = st;
            item.stop_after   = sp;
            item.last         = 1'b0;
            pending_bytes.push_back(item);
        endfunction

        // data command, address command, pattern; colon only when not a raw segment
        function void push_write(input logic [2:0] addr, input logic [BYTE_W-1:0] pat,
                                 input bit allow_colon);
            logic [BYTE_W-1:0] shown;
            shown = pat;
            if (allow_colon && colon_on && addr == 3'd1)
                shown = shown | COLON_BIT;
            push_byte(DATA_CMD_BYTE, 1'b1, 1'b1);
            push_byte(ADDR_CMD_BYTE | {5'b0, addr}, 1'b1, 1'b0);
            push_byte(shown, 1'b0, 1'b1);
        endfunction

        function void note_command(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                                   input logic [VAL_W-1:0] val);
            int               before_n;
            logic [VAL_W-1:0] rest;
            logic [7:0]       v8;
            logic [2:0]       base;
            before_n = pending_bytes.size();
            rest     = val;
            v8       = val[7:0];
            // odd positions put the pair at 0/1, even ones at 2/3
            base     = pos[0] ? 3'd0 : 3'd2;
            case (op)
                OP_CLEAR:
                begin
                    push_byte(DATA_CMD_BYTE, 1'b1, 1'b1);
                    push_byte(ADDR_CMD_BYTE, 1'b1, 1'b0);
                    for (int i = 0; i < CLEAR_COUNT; i++)
                        push_byte(8'h00, 1'b0, i == CLEAR_COUNT - 1);
                    push_byte(BRIGHT_CMD_BYTE | {4'b0, clear_level}, 1'b1, 1'b1);
                end
                OP_BITMAP:  push_write(pos, v8, 1'b1);
                OP_DIGIT:   push_write(pos, glyph(val[3:0]), 1'b1);
                OP_SEGMENT: push_write(pos, (val < 16'd8) ? (8'd1 << val[2:0]) : 8'd0, 1'b0);
                OP_DEC4:
                begin
                    // ones digit first, thousands wraps mod 10
                    for (int i = 3; i >= 0; i--)
                    begin
                        push_write(i[2:0], glyph(4'(rest % 10)), 1'b1);
                        rest = rest / 10;
                    end
                end
                OP_DEC2:
                begin
                    if (pos == 3'd2)
                    begin
                        push_write(3'd2, glyph(4'(v8 % 10)), 1'b1);
                        push_write(3'd1, glyph(4'((v8 / 10) % 10)), 1'b1);
                    end
                    else
                    begin
                        push_write(base + 3'd1, glyph(4'(v8 % 10)), 1'b1);
                        push_write(base, glyph(4'((v8 / 10) % 10)), 1'b1);
                    end
                end
                OP_HEX4:
                begin
                    for (int i = 3; i >= 0; i--)
                    begin
                        push_write(i[2:0], glyph(rest[3:0]), 1'b1);
                        rest = rest >> 4;
                    end
                end
                OP_HEX2:
                begin
                    push_write(base + 3'd1, glyph(v8[3:0]), 1'b1);
                    push_write(base, glyph(v8[7:4]), 1'b1);
                end
                OP_BRIGHTNESS: push_byte(BRIGHT_CMD_BYTE | {4'b0, val[3:0]}, 1'b1, 1'b1);
                default: ;
            endcase
            if (pending_bytes.size() > before_n)
                pending_bytes[pending_bytes.size() - 1].last = 1'b1;
        endfunction

        function void check_byte(input logic [BYTE_W-1:0] b, input logic st, input logic sp,
                                 input logic lst);
            frame_item_t want;
            if (pending_bytes.size() == 0)
            begin
                $error("unexpected frame byte %02h with nothing pending", b);
                mismatches++;
                return;
            end
            want = pending_bytes.pop_front();
            if (b !== want.frame_byte)
            begin
                $error("frame_byte: expected %02h, got %02h", want.frame_byte, b);
                mismatches++;
            end
            if (st !== want.start_before)
            begin
                $error("start_before: expected %0b, got %0b", want.start_before, st);
                mismatches++;
            end
            if (sp !== want.stop_after)
            begin
                $error("stop_after: expected %0b, got %0b", want.stop_after, sp);
                mismatches++;
            end
            if (lst !== want.last)
            begin
                $error("last: expected %0b, got %0b", want.last, lst);
                mismatches++;
            end
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata = '0;   // operation[3:0], position[6:4], value[22:7], pad[23]
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [BYTE_W-1:0]      m_tdata;        // frame_byte[7:0]
    logic [M_TUSER_W-1:0]   m_tuser;        // start_before[0], stop_after[1]
    logic                   m_tlast;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    frame_scoreboard sb = new();
    int unsigned     cycle_count = 0;
    // steady: no idling on either side
    bit              steady = 1'b0;
    // asks the receiver for one long hold-off
    bit              hold_req = 1'b0;

    seven_segment_command_formatter u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // mostly short gaps, now and then a long one
    function int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady)
            return 0;
        if (r < 50)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // values biased toward the interesting corners, full range too
    function logic [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 5))
            0: return VAL_W'($urandom_range(0, 15));
            1: return VAL_W'($urandom_range(0, 255));
            2: return VAL_W'($urandom_range(0, 9999));
            3:
            begin
                case ($urandom_range(0, 3))
                    0: return 16'h0000;
                    1: return 16'hffff;
                    2: return 16'h8000;
                    default: return 16'h00ff;
                endcase
            end
            default: return VAL_W'($urandom_range(0, 65535));
        endcase
    endfunction

    // timeout guard
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // output side: random stalls, one long hold-off on request
    initial
    begin
        int hold_count;
        int rx_gap;
        hold_count = 0;
        rx_gap     = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_count = HOLD_CYCLES;
                hold_req   = 1'b0;
            end
            if (hold_count > 0)
            begin
                m_tready = 1'b0;
                hold_count--;
            end
            else if (rx_gap > 0)
            begin
                m_tready = 1'b0;
                rx_gap--;
            end
            else
            begin
                m_tready = 1'b1;
                if ($urandom_range(0, 3) == 0)
                    rx_gap = pick_gap();
            end
        end
    end

    // every byte taken is checked against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_byte(m_tdata, m_tuser[0], m_tuser[1], m_tlast);
    end

    // offer one command; valid stays up after acceptance so back-to-back items need no gap
    task automatic send_command(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                                input logic [VAL_W-1:0] val, input int gap);
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tdata  = {1'b0, val, pos, op};
        s_tvalid = 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_command(op, pos, val);
    endtask

    // stop offering and let every predicted byte come out, then let the sequencer settle
    task automatic wait_for_idle();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_index = idx;
        cfg_data  = data;
        cfg_valid = 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.set_register(idx, data);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // random commands; unknown operations are mixed in but not counted
    task automatic send_random(input int count, input bit no_gap);
        int               done;
        logic [OP_W-1:0]  op;
        logic [POS_W-1:0] pos;
        done = 0;
        while (done < count)
        begin
            if ($urandom_range(0, 99) < 5)
                op = OP_W'($urandom_range(OP_UNKNOWN_LO, OP_UNKNOWN_HI));
            else
            begin
                op = OP_W'($urandom_range(OP_CLEAR, OP_BRIGHTNESS));
                done++;
            end
            // positions past five are rarer
            if ($urandom_range(0, 9) < 8)
                pos = POS_W'($urandom_range(0, 5));
            else
                pos = POS_W'($urandom_range(6, 7));
            send_command(op, pos, pick_value(), no_gap ? 0 : pick_gap());
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: reset settings, brightness 15 and colon off
        send_command(OP_CLEAR,      3'd0, 16'h0000, 0);
        send_command(OP_BITMAP,     3'd0, 16'hffff, 0);
        send_command(OP_BITMAP,     3'd5, 16'h0000, 0);
        send_command(OP_BITMAP,     3'd7, 16'h00a5, 0);  // address beyond five
        send_command(OP_DIGIT,      3'd1, 16'hffff, 0);  // digit index masked to four bits
        send_command(OP_DIGIT,      3'd6, 16'h0000, 0);
        send_command(OP_SEGMENT,    3'd2, 16'h0000, 0);
        send_command(OP_SEGMENT,    3'd1, 16'h0007, 0);
        send_command(OP_SEGMENT,    3'd3, 16'h0008, 0);  // segment number too large
        send_command(OP_SEGMENT,    3'd4, 16'hffff, 0);
        send_command(OP_DEC4,       3'd0, 16'h0000, 0);
        send_command(OP_DEC4,       3'd7, 16'hffff, 0);  // thousands wraps mod 10
        send_command(OP_DEC4,       3'd0, 16'd12345, 0);
        send_command(OP_DEC2,       3'd2, 16'h00ff, 0);  // special placement for position two
        send_command(OP_DEC2,       3'd0, 16'hff63, 0);
        send_command(OP_DEC2,       3'd1, 16'h0009, 0);
        send_command(OP_DEC2,       3'd7, 16'h0000, 0);
        send_command(OP_HEX4,       3'd0, 16'hffff, 0);
        send_command(OP_HEX4,       3'd0, 16'h1234, 0);
        send_command(OP_HEX2,       3'd0, 16'hffa5, 0);
        send_command(OP_HEX2,       3'd3, 16'h000f, 0);
        send_command(OP_BRIGHTNESS, 3'd0, 16'h0000, 0);
        send_command(OP_BRIGHTNESS, 3'd0, 16'hfff7, 0);  // only the low nibble counts
        send_command(OP_UNKNOWN_LO, 3'd5, 16'hffff, 0);
        send_command(OP_UNKNOWN_HI, 3'd7, 16'h5555, 0);
        wait_for_idle();

        // dim clear level, colon on
        write_reg(REG_CLEAR_BRIGHTNESS, 4'h0);
        write_reg(REG_COLON_ENABLE, {3'b111, 1'b1});
        steady = 1'b1;
        send_random(50, 1'b1);
        steady = 1'b0;
        send_random(70, 1'b0);
        wait_for_idle();

        // full brightness, colon stays on; receiver backs up while items keep coming
        write_reg(REG_CLEAR_BRIGHTNESS, 4'hf);
        write_reg(REG_COLON_ENABLE, {3'b000, 1'b1});
        send_random(10, 1'b0);
        hold_req = 1'b1;
        send_random(30, 1'b1);
        send_random(50, 1'b0);
        wait_for_idle();

        // colon off again; sender pauses until all bytes are out, mid-phase
        write_reg(REG_COLON_ENABLE, {3'b110, 1'b0});
        write_reg(REG_CLEAR_BRIGHTNESS, 4'h7);
        send_random(40, 1'b0);
        wait_for_idle();
        send_random(40, 1'b0);
        wait_for_idle();

        // random settings for the tail
        write_reg(REG_CLEAR_BRIGHTNESS, CFG_DATA_W'($urandom_range(0, 15)));
        write_reg(REG_COLON_ENABLE, CFG_DATA_W'($urandom_range(0, 15)));
        send_random(40, 1'b0);
        wait_for_idle();

        if (sb.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
